// ===== rtl/ud_pkg.sv =====
// ud_pkg: shared types, character constants and hex helpers for the url percent decoder
// no dependencies; imported by every module of the block
`default_nettype none

package ud_pkg;

  // characters the decoder reacts to
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // most bytes one request can produce
  localparam int unsigned MaxOut = 3;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);

  // decoupling queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one decoded request: up to three bytes in order, plus end-of-string flag
  typedef struct packed {
    logic                   last;
    logic [CntW-1:0]        cnt;
    logic [MaxOut-1:0][7:0] data;
  } ud_rec_t;

  // ascii hex digit test, either case
  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
        ((c >= 8'h61) && (c <= 8'h66));
    return r;
  endfunction

  // nibble value of a hex digit, zero for anything else
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= 8'h30) && (c <= 8'h39)) v = c - 8'h30;
    else if ((c >= 8'h41) && (c <= 8'h46)) v = c - 8'h41 + 8'd10;
    else if ((c >= 8'h61) && (c <= 8'h66)) v = c - 8'h61 + 8'd10;
    else v = 8'h00;
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ud_front.sv =====
// ud_front: escape state machine; turns each input byte into one request of 0..3 bytes
// depends on ud_pkg (record type, characters, hex helpers)
`default_nettype none

module ud_front
  import ud_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    acc,       // input byte taken this cycle
  input  wire logic [7:0] byte_i,
  input  wire logic    last_i,
  output ud_rec_t      rec,       // request built from the current byte
  output logic         rec_push   // request holds at least one byte
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_PCT    = 2'd1;
  localparam logic [1:0] MODE_HEX1   = 2'd2;

  logic [1:0]             mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [CntW-1:0]        cnt;
  logic [MaxOut-1:0][7:0] lst;
  logic                   bhex;
  logic                   run_plain;

  // decode one byte against the held escape
  always_comb begin
    cnt       = '0;
    lst       = '0;
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    run_plain = 1'b0;
    bhex      = is_hex(byte_i);
    unique case (mode_r)
      MODE_PCT: begin
        if (bhex) begin
          held_nxt = byte_i;
          mode_nxt = MODE_HEX1;
        end else begin
          lst[cnt]  = CH_PERCENT;
          cnt       = cnt + 1'b1;
          run_plain = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (bhex) begin
          lst[cnt] = {hex_val(held_r), hex_val(byte_i)};
          cnt      = cnt + 1'b1;
          mode_nxt = MODE_NORMAL;
        end else begin
          lst[cnt]  = CH_PERCENT;
          cnt       = cnt + 1'b1;
          lst[cnt]  = held_r;
          cnt       = cnt + 1'b1;
          run_plain = 1'b1;
        end
      end
      default: begin
        run_plain = 1'b1;
      end
    endcase
    // ordinary byte handling, also for the byte that broke an escape
    if (run_plain) begin
      if (byte_i == CH_PERCENT) begin
        mode_nxt = MODE_PCT;
      end else begin
        mode_nxt = MODE_NORMAL;
        lst[cnt] = (byte_i == CH_PLUS) ? CH_SPACE : byte_i;
        cnt      = cnt + 1'b1;
      end
    end
    // end of string flushes whatever escape is still open
    if (last_i) begin
      if (mode_nxt == MODE_PCT) begin
        lst[cnt] = CH_PERCENT;
        cnt      = cnt + 1'b1;
      end else if (mode_nxt == MODE_HEX1) begin
        lst[cnt] = CH_PERCENT;
        cnt      = cnt + 1'b1;
        lst[cnt] = held_nxt;
        cnt      = cnt + 1'b1;
      end
      mode_nxt = MODE_NORMAL;
    end
  end

  assign rec.last = last_i;
  assign rec.cnt  = cnt;
  assign rec.data = lst;
  assign rec_push = acc && (cnt != '0);

  // escape mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (acc) begin
      mode_r <= mode_nxt;
    end
  end

  // held first digit, payload only
  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ud_fifo.sv =====
// ud_fifo: short request queue between decoder front and output back
// depends on ud_pkg (record type, queue depth)
`default_nettype none

module ud_fifo
  import ud_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire ud_rec_t wr_rec,
  output logic         full,
  input  wire logic    pop,
  output logic         rd_valid,
  output ud_rec_t      rd_rec
);

  ud_rec_t           mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0]  cnt_r;
  logic              do_pop;

  assign full     = (cnt_r == QCntW'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign do_pop   = pop && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ud_back.sv =====
// ud_back: walks each queued request byte by byte into a registered output stage
// depends on ud_pkg (record type)
`default_nettype none

module ud_back
  import ud_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    rd_valid,
  input  wire ud_rec_t rd_rec,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [7:0]   out_byte,
  output logic         out_last
);

  logic [CntW-1:0] idx_r;
  logic            ovalid_r;
  logic [7:0]      obyte_r;
  logic            olast_r;
  logic            load;
  logic            at_end;

  assign load      = rd_valid && (!ovalid_r || out_ready);
  assign at_end    = (idx_r == (rd_rec.cnt - 1'b1));
  assign pop       = load && at_end;
  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

  // byte index within the head request, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (load) begin
        ovalid_r <= 1'b1;
        idx_r    <= at_end ? '0 : idx_r + 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      obyte_r <= rd_rec.data[idx_r[1:0]];
      olast_r <= rd_rec.last && at_end;
    end
  end

`ifndef SYNTHESIS
  // the index always points inside the head request
  a_idx_in_rec: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> (idx_r < rd_rec.cnt))
    else $error("byte index beyond head request");

  // empty requests never reach the queue
  a_rec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> (rd_rec.cnt != '0))
    else $error("empty request in queue");

  // with no request waiting the walk restarts at the first byte
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !rd_valid |-> (idx_r == '0))
    else $error("byte index left mid request");

  // a loaded byte is presented in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ovalid_r)
    else $error("loaded byte not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/url_percent_decoder.sv =====
// url_percent_decoder: top level of the streaming form-urlencoded decoder
// depends on ud_pkg, ud_front, ud_fifo, ud_back
`default_nettype none

// Streaming percent decoder. One encoded byte enters per request on the in_ side,
// tlast marking the end of a string. "%hh" (either case) becomes one byte, '+'
// becomes a space, other bytes pass through; a broken escape is emitted literally
// and the breaking byte handled normally, and an open escape is flushed at tlast,
// which always lands on the final output byte of the string. The front decodes a
// byte in the cycle it is accepted and queues the 0..3 resulting bytes as one
// request in a two-deep queue; the back sends one byte per cycle from a register
// while the output is ready. Throughput is one input byte per cycle while each
// byte yields at most one output byte; a request that yields several bytes is
// sent one byte at a time, so input is held off only when the queue fills behind
// such bursts or output backpressure.
module url_percent_decoder
  import ud_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast
);

  ud_rec_t rec, head;
  logic    acc, push, full, pop, rd_valid;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  // decode front
  ud_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .byte_i   (in_tdata),
    .last_i   (in_tlast),
    .rec      (rec),
    .rec_push (push)
  );

  // request queue
  ud_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_rec   (rec),
    .full     (full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_rec   (head)
  );

  // output back
  ud_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_rec    (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for url_percent_decoder, with a byte-level decode predictor,
// a queued stream driver and a checking output monitor
// depends on ud_pkg and rtl/url_percent_decoder.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ud_pkg::*;

  // escape tracking of the predictor
  typedef enum logic [1:0] {
    DM_NORMAL = 2'd0,
    DM_PCT    = 2'd1,
    DM_HEX1   = 2'd2
  } dec_mode_t;

  // one byte on either stream with its end-of-string flag
  typedef struct {
    logic [7:0] data;
    logic       last;
  } beat_t;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_LEN    = 150;
  localparam int SETTLE      = 10;
  localparam int MAX_PRINTS  = 40;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;

  beat_t pend_q[$];      // encoded bytes waiting to be offered
  beat_t decoded_q[$];   // decoded bytes still owed by the block

  dec_mode_t  dec_mode = DM_NORMAL;
  logic [7:0] held_char;

  int tx_idle_pct  = 9;
  int rx_idle_pct  = 71;
  logic hold_go    = 1'b0;
  logic hold_seen  = 1'b0;
  int hold_cycles  = 0;
  int cycle_cnt    = 0;
  int err_cnt      = 0;
  int items_queued = 0;
  int items_sent   = 0;
  int strings_sent = 0;
  int bytes_seen   = 0;

  url_percent_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // nibble of an ascii hex digit, -1 when the byte is not one
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int nib;
    nib = $urandom_range(0, 15);
    if (nib < 10) return 8'(8'h30 + nib);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 10);
  endfunction

  // work out the decoded bytes one accepted request causes
  task automatic decode_request(input logic [7:0] b, input logic l);
    beat_t res[$];
    beat_t r;
    int hi;
    int lo;
    logic taken;
    hi = nibble_of(held_char);
    lo = nibble_of(b);
    taken = 1'b0;
    r.last = 1'b0;
    case (dec_mode)
      DM_PCT: begin
        if (lo >= 0) begin
          held_char = b;
          dec_mode = DM_HEX1;
          taken = 1'b1;
        end else begin
          r.data = CH_PERCENT;
          res.push_back(r);
          dec_mode = DM_NORMAL;
        end
      end
      DM_HEX1: begin
        if (lo >= 0) begin
          r.data = 8'(hi * 16 + lo);
          res.push_back(r);
          dec_mode = DM_NORMAL;
          taken = 1'b1;
        end else begin
          r.data = CH_PERCENT;
          res.push_back(r);
          r.data = held_char;
          res.push_back(r);
          dec_mode = DM_NORMAL;
        end
      end
      default: dec_mode = DM_NORMAL;
    endcase
    // byte not swallowed by an escape is handled as plain text
    if (!taken) begin
      if (b == CH_PERCENT) begin
        dec_mode = DM_PCT;
      end else begin
        r.data = (b == CH_PLUS) ? CH_SPACE : b;
        res.push_back(r);
      end
    end
    // end of string flushes an open escape
    if (l) begin
      if (dec_mode != DM_NORMAL) begin
        r.data = CH_PERCENT;
        res.push_back(r);
      end
      if (dec_mode == DM_HEX1) begin
        r.data = held_char;
        res.push_back(r);
      end
      dec_mode = DM_NORMAL;
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    end
    foreach (res[i]) decoded_q.push_back(res[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    if (err_cnt < MAX_PRINTS)
      $display("%0t: %s, expected %02h, got %02h", $time, what, want, got);
    err_cnt++;
  endtask

  task automatic add_item(input logic [7:0] b, input logic l);
    beat_t it;
    it.data = b;
    it.last = l;
    pend_q.push_back(it);
    items_queued++;
    if (l) strings_sent++;
  endtask

  task automatic add_text(input string t, input logic l);
    for (int i = 0; i < t.len(); i++) add_item(8'(t[i]), l && (i == t.len() - 1));
  endtask

  // mostly well-formed escapes, with plain bytes, plus signs and broken escapes mixed in;
  // the length cut can leave an escape open at the end of the string
  task automatic add_random_string(input int max_len);
    logic [7:0] s[$];
    int len;
    int pick;
    len = $urandom_range(1, max_len);
    while (s.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        s.push_back(CH_PERCENT);
        s.push_back(rand_hex_char());
        s.push_back(rand_hex_char());
      end else if (pick < 55) begin
        s.push_back(CH_PLUS);
      end else if (pick < 85) begin
        s.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 93) begin
        s.push_back(CH_PERCENT);
        s.push_back(8'($urandom_range(1, 255)));
      end else begin
        s.push_back(CH_PERCENT);
        s.push_back(rand_hex_char());
        s.push_back(8'($urandom_range(1, 255)));
      end
    end
    for (int i = 0; i < len; i++) add_item(s[i], i == len - 1);
  endtask

  task automatic run_random(input int n);
    int start;
    start = items_queued;
    while (items_queued - start < n) add_random_string(10);
  endtask

  // sender pause: nothing more offered until every decoded byte is back
  task automatic wait_drained();
    while (pend_q.size() != 0 || decoded_q.size() != 0) @(negedge clk);
  endtask

  // input driver: hold a request until taken, then maybe offer the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_request(in_tdata, in_tlast);
        void'(pend_q.pop_front());
        items_sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pend_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pend_q[0].data;
          in_tlast  <= pend_q[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, loaded once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (hold_go && !hold_seen) begin
      hold_cycles <= HOLD_LEN;
      hold_seen   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // output monitor: check each taken byte against the oldest owed one
  always @(posedge clk) begin : rx_side
    beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        bytes_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch("output byte with none owed", 8'h00, out_tdata);
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data)
            report_mismatch("out_byte", want.data, out_tdata);
          if (out_tlast !== want.last)
            report_mismatch("out_last", 8'(want.last), 8'(out_tlast));
        end
      end
      out_tready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_cnt, decoded_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus and phase control
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: byte extremes, clean escapes in both cases, plus signs,
    // broken escapes, and open escapes flushed at end of string
    add_item(8'h01, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h80, 1'b0);
    add_text("+%41%fF%00", 1'b0);
    add_text("%G%7+%9%a", 1'b1);
    add_text("%", 1'b1);
    add_text("%B", 1'b1);
    add_text("+", 1'b1);

    // sender mostly busy, receiver mostly stalling
    run_random(70);
    wait_drained();

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 71;
    rx_idle_pct = 9;
    run_random(70);
    wait_drained();

    // no idling, opened by a long receiver hold-off to back the block up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b1;
    run_random(70);
    wait_drained();

    repeat (SETTLE) @(negedge clk);
    $display("%0d strings, %0d encoded bytes in, %0d decoded bytes checked, %0d mismatches",
             strings_sent, items_sent, bytes_seen, err_cnt);
    $display("covered clean and broken escapes, plus signs, open escapes at end, stalls");
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
